// File: design/sql_token_scanner_top_assert.svh
// assertion macros for the sql token scanner
// used by sql_token_scanner_top; no other dependencies
`ifndef SQL_TOKEN_SCANNER_TOP_ASSERT_SVH
`define SQL_TOKEN_SCANNER_TOP_ASSERT_SVH
`ifndef SYNTH
`define SQLTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqlts check failed");
`define SQLTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqlts check failed");
`else
`define SQLTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SQLTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/sqlts_pkg.sv
`timescale 1ns / 1ps
// shared types, token codes and keyword table for the sql token scanner
// no dependencies
package sqlts_pkg;

    typedef enum logic [4:0] {
        K_INT     = 5'd0,  K_FLOAT  = 5'd1,  K_STRING = 5'd2,  K_IDENT  = 5'd3,
        K_KEYWORD = 5'd4,  K_PLUS   = 5'd5,  K_MINUS  = 5'd6,  K_STAR   = 5'd7,
        K_SLASH   = 5'd8,  K_PERCENT = 5'd9, K_EQ     = 5'd10, K_NE     = 5'd11,
        K_LT      = 5'd12, K_LE     = 5'd13, K_GT     = 5'd14, K_GE     = 5'd15,
        K_ASSIGN  = 5'd16, K_LPAREN = 5'd17, K_RPAREN = 5'd18, K_COMMA  = 5'd19,
        K_SEMI    = 5'd20, K_DOT    = 5'd21, K_EOF    = 5'd22, K_INVALID = 5'd23
    } t_kind;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [6:0]  keyword_code;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] lexeme_length;
        logic [62:0] int_value;
        logic        value_overflow;
        logic        last_of_run;
    } t_token;

    typedef struct packed {
        logic [1:0]       count;
        t_token [2:0]     tok;
    } t_push;

    // keyword matcher control from the scanner
    typedef struct packed {
        logic       start;
        logic       step;
        logic       far;
        logic [3:0] pos;
        logic [7:0] ch;
    } t_kw_ctl;

    localparam int KW_CHARS   = 14;
    localparam int KW_ENTRIES = 112;
    localparam int KW_BOOL_ENTRY = 111;
    localparam logic [6:0] KW_BOOL_CODE = 7'd72;

    // right-justified, zero padded; last entry is the alias bool
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_ENTRIES] = '{
        "select", "from", "where", "insert", "update", "delete", "create", "drop",
        "alter", "table", "index", "into", "values", "set", "join", "inner",
        "left", "right", "full", "outer", "cross", "on", "and", "or", "not", "is",
        "null", "like", "in", "between", "exists", "order", "by", "asc", "desc",
        "group", "having", "limit", "offset", "as", "distinct", "all", "count",
        "sum", "avg", "min", "max", "case", "when", "then", "else", "end", "if",
        "primary", "key", "foreign", "references", "unique", "using", "check",
        "default", "int", "bigint", "float", "double", "decimal", "char",
        "varchar", "text", "date", "time", "datetime", "boolean", "blob", "true",
        "false", "begin", "commit", "rollback", "transaction", "show", "tables",
        "indexes", "database", "databases", "use", "describe", "explain",
        "analyze", "save", "vacuum", "grant", "revoke", "to", "with", "option",
        "user", "password", "identified", "add", "modify", "rename", "column",
        "constraint", "cascade", "union", "intersect", "except", "match",
        "against", {"auto_", "increment"}, "bool"
    };

    function automatic logic [3:0] kw_len(input int idx);
        logic [3:0] n;
        n = 4'd0;
        for (int j = 0; j < KW_CHARS; j++) begin
            if (KW_TEXT[idx][8*j +: 8] != 8'h00) n = n + 4'd1;
        end
        return n;
    endfunction

    function automatic logic [7:0] kw_byte(input int idx, input logic [3:0] pos);
        logic [3:0] n;
        logic [7:0] b;
        n = kw_len(idx);
        b = 8'h00;
        for (int j = 0; j < KW_CHARS; j++) begin
            if (pos < n && 4'(j) == n - 4'd1 - pos) b = KW_TEXT[idx][8*j +: 8];
        end
        return b;
    endfunction

endpackage

// File: design/sqlts_if.sv
`timescale 1ns / 1ps
// valid/ready channels for source bytes and tokens
// no dependencies
interface sqlts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;
    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface sqlts_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [6:0]  keyword_code;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] lexeme_length;
    logic [62:0] int_value;
    logic        value_overflow;
    logic        last_of_run;
    modport source (output valid, output token_kind, output keyword_code,
                    output start_line, output start_column, output lexeme_length,
                    output int_value, output value_overflow, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input keyword_code,
                  input start_line, input start_column, input lexeme_length,
                  input int_value, input value_overflow, input last_of_run,
                  output ready);
endinterface

// File: design/sqlts_kw_match.sv
`timescale 1ns / 1ps
// keyword candidate mask, narrowed one identifier character per item
// depends on sqlts_pkg
module sqlts_kw_match (
    input  logic             i_clk,
    input  sqlts_pkg::t_kw_ctl i_ctl,
    input  logic [15:0]      i_len,
    output logic             o_hit,
    output logic [6:0]       o_code
);
    import sqlts_pkg::*;

    logic [KW_ENTRIES-1:0] r_cand;
    logic [KW_ENTRIES-1:0] n_cand;

    always_comb begin
        n_cand = r_cand;
        for (int i = 0; i < KW_ENTRIES; i++) begin
            if (i_ctl.start) begin
                n_cand[i] = (kw_byte(i, 4'd0) == i_ctl.ch);
            end else if (i_ctl.step) begin
                n_cand[i] = r_cand[i] && !i_ctl.far && (kw_byte(i, i_ctl.pos) == i_ctl.ch);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    // lowest matching entry wins; bool maps onto boolean
    always_comb begin
        o_hit  = 1'b0;
        o_code = 7'd0;
        for (int i = KW_ENTRIES - 1; i >= 0; i--) begin
            if (r_cand[i] && i_len == 16'(kw_len(i))) begin
                o_hit  = 1'b1;
                o_code = (i == KW_BOOL_ENTRY) ? KW_BOOL_CODE : 7'(i);
            end
        end
    end

endmodule

// File: design/sqlts_core.sv
`timescale 1ns / 1ps
// scanner state and token generation, one byte per accepted item
// depends on sqlts_pkg and sqlts_kw_match
module sqlts_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_char,
    input  logic              i_eoi,
    output sqlts_pkg::t_push  o_push
);
    import sqlts_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int SW = ((PB > 16) ? PB : 16) + 1;

    typedef enum logic [3:0] {
        M_IDLE, M_INT, M_INT_DOT, M_FRAC, M_EXP, M_EXPD, M_STR, M_STR_ESC,
        M_IDENT, M_PEND, M_LCOM, M_BCOM, M_BSTAR
    } t_mode;

    t_mode         r_mode, n_mode;
    logic [15:0]   r_len, n_len;
    logic [PB-1:0] r_cur_line, n_cur_line, r_cur_col, n_cur_col;
    logic [PB-1:0] r_tok_line, n_tok_line, r_tok_col, n_tok_col;
    logic [62:0]   r_acc, n_acc;
    logic          r_ovf, n_ovf;
    logic          r_dq, n_dq;
    logic [7:0]    r_held, n_held;

    t_kw_ctl       kw_ctl;
    logic          kw_hit;
    logic [6:0]    kw_code;

    t_token [2:0]  e;
    logic [1:0]    ne;
    logic          flush, feed, eof, cons;
    logic [7:0]    c, lc;
    logic          is_dig, is_alpha, is_word, is_space;
    logic [66:0]   prod;
    logic [SW-1:0] dot_sum;
    logic [PB-1:0] dot_col;
    t_kind         pk, sk;

    sqlts_kw_match u_kw (
        .i_clk  (i_clk),
        .i_ctl  (kw_ctl),
        .i_len  (r_len),
        .o_hit  (kw_hit),
        .o_code (kw_code)
    );

    function automatic t_token mk_tok(input t_kind k, input logic [6:0] kw,
                                      input logic [PB-1:0] ln, input logic [PB-1:0] col,
                                      input logic [15:0] len, input logic [62:0] v,
                                      input logic ovf);
        t_token t;
        t.token_kind     = k;
        t.keyword_code   = kw;
        t.start_line     = 16'(ln);
        t.start_column   = 16'(col);
        t.lexeme_length  = len;
        t.int_value      = v;
        t.value_overflow = ovf;
        t.last_of_run    = 1'b0;
        return t;
    endfunction

    function automatic logic [15:0] len_inc(input logic [15:0] x);
        return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

    function automatic logic [PB-1:0] pos_inc(input logic [PB-1:0] x);
        return (x == {PB{1'b1}}) ? x : x + PB'(1);
    endfunction

    assign c        = i_char;
    assign lc       = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    assign is_dig   = (c >= "0" && c <= "9");
    assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_word  = is_alpha || is_dig || c == "_";
    assign is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    // acc * 10 + digit, overflow when it leaves 63 bits
    assign prod     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 67'(c - "0");
    assign dot_sum  = SW'(r_tok_col) + SW'(r_len);
    assign dot_col  = (dot_sum > SW'({PB{1'b1}})) ? {PB{1'b1}} : PB'(dot_sum);

    always_comb begin
        unique case (r_held)
            "<":     pk = (c == "=") ? K_LE : ((c == ">") ? K_NE : K_INVALID);
            ">":     pk = (c == "=") ? K_GE : K_INVALID;
            "!":     pk = (c == "=") ? K_NE : K_INVALID;
            ":":     pk = (c == "=") ? K_ASSIGN : K_INVALID;
            default: pk = K_INVALID;
        endcase
        unique case (c)
            "+":     sk = K_PLUS;
            "*":     sk = K_STAR;
            "%":     sk = K_PERCENT;
            "(":     sk = K_LPAREN;
            ")":     sk = K_RPAREN;
            ",":     sk = K_COMMA;
            ";":     sk = K_SEMI;
            ".":     sk = K_DOT;
            "=":     sk = K_EQ;
            default: sk = K_INVALID;
        endcase
    end

    always_comb begin
        n_mode = r_mode;   n_len = r_len;
        n_cur_line = r_cur_line; n_cur_col = r_cur_col;
        n_tok_line = r_tok_line; n_tok_col = r_tok_col;
        n_acc = r_acc; n_ovf = r_ovf; n_dq = r_dq; n_held = r_held;
        e = '0; ne = 2'd0;
        flush = 1'b0; feed = 1'b0; eof = 1'b0; cons = 1'b0;
        kw_ctl = '0;
        kw_ctl.ch  = lc;
        kw_ctl.pos = r_len[3:0];
        kw_ctl.far = (r_len >= 16'(KW_CHARS));

        if (i_eoi || c == 8'h00) begin
            flush = 1'b1;
            eof   = 1'b1;
        end else begin
            unique case (r_mode)
                M_INT: begin
                    if (is_dig) begin
                        cons = 1'b1;
                        if (!r_ovf) begin
                            if (prod[66:63] != 4'd0) n_ovf = 1'b1;
                            else n_acc = prod[62:0];
                        end
                        n_len = len_inc(r_len);
                    end else if (c == ".") begin
                        cons = 1'b1;
                        n_mode = M_INT_DOT;
                    end
                end
                M_INT_DOT: begin
                    if (is_dig) begin
                        cons = 1'b1;
                        n_len = len_inc(len_inc(r_len));
                        n_mode = M_FRAC;
                    end
                end
                M_FRAC: begin
                    if (is_dig) begin
                        cons = 1'b1;
                        n_len = len_inc(r_len);
                    end else if (c == "e" || c == "E") begin
                        cons = 1'b1;
                        n_len = len_inc(r_len);
                        n_mode = M_EXP;
                    end
                end
                M_EXP: begin
                    if (c == "+" || c == "-" || is_dig) begin
                        cons = 1'b1;
                        n_len = len_inc(r_len);
                        n_mode = M_EXPD;
                    end
                end
                M_EXPD: begin
                    if (is_dig) begin
                        cons = 1'b1;
                        n_len = len_inc(r_len);
                    end
                end
                M_STR: begin
                    cons = 1'b1;
                    if (c == (r_dq ? 8'h22 : 8'h27)) begin
                        e[ne] = mk_tok(K_STRING, 7'd0, r_tok_line, r_tok_col, r_len, '0, 1'b0);
                        ne = ne + 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == 8'h5C) begin
                        n_mode = M_STR_ESC;
                    end else begin
                        n_len = len_inc(r_len);
                    end
                end
                M_STR_ESC: begin
                    cons = 1'b1;
                    n_len = len_inc(r_len);
                    n_mode = M_STR;
                end
                M_IDENT: begin
                    if (is_word) begin
                        cons = 1'b1;
                        kw_ctl.step = 1'b1;
                        n_len = len_inc(r_len);
                    end
                end
                M_PEND: begin
                    if (r_held == "-" && c == "-") begin
                        cons = 1'b1;
                        n_mode = M_LCOM;
                    end else if (r_held == "/" && c == "*") begin
                        cons = 1'b1;
                        n_mode = M_BCOM;
                    end else if (pk != K_INVALID) begin
                        cons = 1'b1;
                        e[ne] = mk_tok(pk, 7'd0, r_tok_line, r_tok_col, 16'd2, '0, 1'b0);
                        ne = ne + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_LCOM: begin
                    cons = 1'b1;
                    if (c == 8'h0A) n_mode = M_IDLE;
                end
                M_BCOM: begin
                    cons = 1'b1;
                    if (c == "*") n_mode = M_BSTAR;
                end
                M_BSTAR: begin
                    cons = 1'b1;
                    if (c == "/") n_mode = M_IDLE;
                    else if (c != "*") n_mode = M_BCOM;
                end
                default: cons = 1'b0;
            endcase
            if (!cons) begin
                flush = 1'b1;
                feed  = 1'b1;
            end
        end

        // pending token out, uses the state as it stood
        if (flush) begin
            unique case (r_mode)
                M_INT, M_INT_DOT: begin
                    e[ne] = mk_tok(K_INT, 7'd0, r_tok_line, r_tok_col, r_len,
                                   r_ovf ? 63'd0 : r_acc, r_ovf);
                    ne = ne + 2'd1;
                    if (r_mode == M_INT_DOT) begin
                        e[ne] = mk_tok(K_DOT, 7'd0, r_tok_line, dot_col, 16'd1, '0, 1'b0);
                        ne = ne + 2'd1;
                    end
                end
                M_FRAC, M_EXP, M_EXPD: begin
                    e[ne] = mk_tok(K_FLOAT, 7'd0, r_tok_line, r_tok_col, r_len, '0, 1'b0);
                    ne = ne + 2'd1;
                end
                M_STR, M_STR_ESC: begin
                    e[ne] = mk_tok(K_INVALID, 7'd0, r_tok_line, r_tok_col, r_len, '0, 1'b0);
                    ne = ne + 2'd1;
                end
                M_IDENT: begin
                    e[ne] = mk_tok(kw_hit ? K_KEYWORD : K_IDENT, kw_hit ? kw_code : 7'd0,
                                   r_tok_line, r_tok_col, r_len, '0, 1'b0);
                    ne = ne + 2'd1;
                end
                M_PEND: begin
                    e[ne] = mk_tok((r_held == "-") ? K_MINUS :
                                   (r_held == "/") ? K_SLASH :
                                   (r_held == "<") ? K_LT :
                                   (r_held == ">") ? K_GT : K_INVALID,
                                   7'd0, r_tok_line, r_tok_col, 16'd1, '0, 1'b0);
                    ne = ne + 2'd1;
                end
                default: ;
            endcase
            n_mode = M_IDLE;
        end

        if (feed && !is_space) begin
            if (is_dig) begin
                n_mode = M_INT;
                n_tok_line = r_cur_line; n_tok_col = r_cur_col;
                n_acc = 63'(c - "0");
                n_ovf = 1'b0;
                n_len = 16'd1;
            end else if (c == 8'h27 || c == 8'h22) begin
                n_mode = M_STR;
                n_tok_line = r_cur_line; n_tok_col = r_cur_col;
                n_len = 16'd0;
                n_dq = (c == 8'h22);
            end else if (is_alpha || c == "_") begin
                n_mode = M_IDENT;
                n_tok_line = r_cur_line; n_tok_col = r_cur_col;
                n_len = 16'd1;
                kw_ctl.start = 1'b1;
            end else if (c == "-" || c == "/" || c == "<" || c == ">" || c == "!"
                         || c == ":") begin
                n_mode = M_PEND;
                n_tok_line = r_cur_line; n_tok_col = r_cur_col;
                n_len = 16'd0;
                n_held = c;
            end else begin
                e[ne] = mk_tok(sk, 7'd0, r_cur_line, r_cur_col, 16'd1, '0, 1'b0);
                ne = ne + 2'd1;
            end
        end

        if (eof) begin
            e[ne] = mk_tok(K_EOF, 7'd0, r_cur_line, r_cur_col, 16'd0, '0, 1'b0);
            ne = ne + 2'd1;
            n_mode = M_IDLE; n_len = 16'd0;
            n_cur_line = PB'(1); n_cur_col = PB'(1);
            n_tok_line = PB'(1); n_tok_col = PB'(1);
            n_acc = 63'd0; n_ovf = 1'b0; n_dq = 1'b0; n_held = 8'h00;
        end else if (c == 8'h0A) begin
            n_cur_line = pos_inc(r_cur_line);
            n_cur_col  = PB'(1);
        end else begin
            n_cur_col = pos_inc(r_cur_col);
        end

        if (!i_take) kw_ctl.start = 1'b0;
        if (!i_take) kw_ctl.step = 1'b0;
    end

    assign o_push.count = i_take ? ne : 2'd0;
    assign o_push.tok   = e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_len <= 16'd0;
            r_cur_line <= PB'(1); r_cur_col <= PB'(1);
            r_tok_line <= PB'(1); r_tok_col <= PB'(1);
            r_acc <= 63'd0; r_ovf <= 1'b0; r_dq <= 1'b0; r_held <= 8'h00;
        end else if (i_take) begin
            r_mode <= n_mode; r_len <= n_len;
            r_cur_line <= n_cur_line; r_cur_col <= n_cur_col;
            r_tok_line <= n_tok_line; r_tok_col <= n_tok_col;
            r_acc <= n_acc; r_ovf <= n_ovf; r_dq <= n_dq; r_held <= n_held;
        end
    end

endmodule

// File: design/sqlts_out_fifo.sv
`timescale 1ns / 1ps
// four-entry token queue, takes up to three tokens at once, gives one a cycle while the reader is ready
// depends on sqlts_pkg
module sqlts_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sqlts_pkg::t_push i_push,
    input  logic             i_ready,
    output logic             o_valid,
    output sqlts_pkg::t_token o_head,
    output logic             o_room
);
    import sqlts_pkg::*;

    t_token       r_mem [4];
    logic [1:0]   r_wp, r_rp;
    logic [2:0]   r_cnt;
    logic         pop;
    t_token [2:0] wr_tok;

    assign o_valid = (r_cnt != 3'd0);
    assign o_head  = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    // room for the worst case of three tokens from one item
    assign o_room  = (r_cnt <= 3'd1);

    // mark the last token of the item
    always_comb begin
        wr_tok = i_push.tok;
        for (int k = 0; k < 3; k++) begin
            wr_tok[k].last_of_run = (2'(k) == i_push.count - 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < i_push.count) begin
                r_mem[r_wp + 2'(k)] <= wr_tok[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + i_push.count;
            r_rp  <= r_rp + 2'(pop);
            r_cnt <= r_cnt + 3'(i_push.count) - 3'(pop);
        end
    end

endmodule

// File: design/sql_token_scanner_top.sv
`timescale 1ns / 1ps
// Streaming SQL token scanner: takes one source byte per cycle and returns
// tokens with kind, keyword code, start position, length and integer value.
// A byte is scanned in the cycle it is accepted; its tokens can be taken
// from the output in the next cycle, one token per cycle while the sink is
// ready, from a four-entry queue. The input accepts a byte in every cycle
// while that queue holds at most one token, so bytes that give one token or
// none each go at one byte per cycle while the sink keeps up; a byte that
// gives two or three tokens (a number ending in a dot, end of input) holds
// the input while the queue drains. Keyword lookup narrows a candidate
// mask per character, never stalling. No clearing pass follows reset.
// depends on sqlts_pkg, sqlts_if, sqlts_core, sqlts_out_fifo
`include "sql_token_scanner_top_assert.svh"
module sql_token_scanner_top #(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sqlts_in_if.sink    i_src,
    sqlts_out_if.source o_tok
);
    import sqlts_pkg::*;

    t_push  push;
    t_token head;
    logic   room;
    logic   take;

    assign i_src.ready = i_rst_n && room;
    assign take        = i_src.valid && i_src.ready;

    sqlts_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_char (i_src.char_code),
        .i_eoi  (i_src.end_of_input),
        .o_push (push)
    );

    sqlts_out_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_ready(o_tok.ready),
        .o_valid(o_tok.valid),
        .o_head (head),
        .o_room (room)
    );

    assign o_tok.token_kind     = head.token_kind;
    assign o_tok.keyword_code   = head.keyword_code;
    assign o_tok.start_line     = head.start_line;
    assign o_tok.start_column   = head.start_column;
    assign o_tok.lexeme_length  = head.lexeme_length;
    assign o_tok.int_value      = head.int_value;
    assign o_tok.value_overflow = head.value_overflow;
    assign o_tok.last_of_run    = head.last_of_run;

    `SQLTS_ASSERT_NEXT(a_eof_queued, i_clk, i_rst_n, take && i_src.end_of_input, o_tok.valid)
    `SQLTS_ASSERT_NOW(a_eof_last, i_clk, i_rst_n, o_tok.valid && o_tok.token_kind == K_EOF, o_tok.last_of_run)
    `SQLTS_ASSERT_NOW(a_value_int_only, i_clk, i_rst_n, o_tok.valid && o_tok.token_kind != K_INT, o_tok.int_value == 63'd0 && !o_tok.value_overflow)
    `SQLTS_ASSERT_NOW(a_ovf_zero, i_clk, i_rst_n, o_tok.valid && o_tok.value_overflow, o_tok.int_value == 63'd0)

endmodule

// File: verif/sql_token_scanner_top_test.sv
`timescale 1ns / 1ps
// self-checking bench for sql_token_scanner_top: random and directed sql byte
// streams, tokens predicted in-bench and compared field by field
// depends on sqlts_pkg, sqlts_if and the scanner rtl
module sql_token_scanner_top_test;
    import sqlts_pkg::*;

    typedef enum {
        S_IDLE, S_INT, S_INT_DOT, S_FRAC, S_EXP, S_EXPD, S_STR, S_ESC,
        S_IDENT, S_PEND, S_LCOM, S_BCOM, S_BSTAR
    } t_scan;

    typedef struct {
        byte unsigned code;
        bit           eoi;
    } t_src_item;

    localparam int unsigned POS_MAX = 65535;
    localparam int unsigned LEN_MAX = 65535;
    localparam int          LEX_CHARS = 16;
    localparam longint unsigned VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          STALL_LIMIT = 5000;

    string kw_words[111] = '{
        "select", "from", "where", "insert", "update", "delete", "create", "drop",
        "alter", "table", "index", "into", "values", "set", "join", "inner",
        "left", "right", "full", "outer", "cross", "on", "and", "or", "not", "is",
        "null", "like", "in", "between", "exists", "order", "by", "asc", "desc",
        "group", "having", "limit", "offset", "as", "distinct", "all", "count",
        "sum", "avg", "min", "max", "case", "when", "then", "else", "end", "if",
        "primary", "key", "foreign", "references", "unique", "using", "check",
        "default", "int", "bigint", "float", "double", "decimal", "char",
        "varchar", "text", "date", "time", "datetime", "boolean", "blob", "true",
        "false", "begin", "commit", "rollback", "transaction", "show", "tables",
        "indexes", "database", "databases", "use", "describe", "explain",
        "analyze", "save", "vacuum", "grant", "revoke", "to", "with", "option",
        "user", "password", "identified", "add", "modify", "rename", "column",
        "constraint", "cascade", "union", "intersect", "except", "match",
        "against", {"auto_", "increment"}
    };
    localparam int BOOLEAN_CODE = 72;

    logic i_clk;
    logic i_rst_n = 1'b0;

    sqlts_in_if  src_ch ();
    sqlts_out_if tok_ch ();

    sql_token_scanner_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_ch),
        .o_tok   (tok_ch)
    );

    t_src_item byte_q[$];
    t_token    token_q[$];
    t_token    step_toks[$];
    int        src_idle_pct;
    int        snk_idle_pct;
    int        n_errors;
    int        n_bytes;
    int        n_tokens;
    int        n_added;
    int        stall_cnt;

    // scanner state mirror
    t_scan           mode;
    byte unsigned    lex[LEX_CHARS];
    int unsigned     tok_len;
    int unsigned     cur_line, cur_col, tok_line, tok_col;
    longint unsigned acc;
    bit              acc_ovf;
    byte unsigned    quote_ch, held_ch;

    function automatic bit is_digit(byte unsigned c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(byte unsigned c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic byte unsigned lower(byte unsigned c);
        return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    function automatic int unsigned sat_pos(int unsigned v);
        return v > POS_MAX ? POS_MAX : v;
    endfunction

    function void clear_scan();
        mode = S_IDLE;
        tok_len = 0;
        cur_line = 1;
        cur_col = 1;
        tok_line = 1;
        tok_col = 1;
        acc = 0;
        acc_ovf = 0;
        quote_ch = 0;
        held_ch = 0;
    endfunction

    function void add_token(t_kind kind, int kw, int unsigned line, int unsigned col,
                            int unsigned len, longint unsigned val, bit ovf);
        t_token t;
        t.token_kind = kind;
        t.keyword_code = kw[6:0];
        t.start_line = line[15:0];
        t.start_column = col[15:0];
        t.lexeme_length = len[15:0];
        t.int_value = val[62:0];
        t.value_overflow = ovf;
        t.last_of_run = 1'b0;
        if (step_toks.size() < 3) step_toks.push_back(t);
    endfunction

    function void add_simple(t_kind kind, int unsigned len);
        add_token(kind, 0, tok_line, tok_col, len, 0, 0);
    endfunction

    function void bump_len();
        if (tok_len < LEN_MAX) tok_len++;
    endfunction

    function automatic int keyword_index();
        bit hit;
        if (tok_len > LEX_CHARS) return -1;
        if (tok_len == 4 && lex[0] == "b" && lex[1] == "o" && lex[2] == "o" && lex[3] == "l")
            return BOOLEAN_CODE;
        for (int i = 0; i < 111; i++) begin
            if (kw_words[i].len() == tok_len) begin
                hit = 1;
                for (int j = 0; j < tok_len; j++)
                    if (kw_words[i][j] != lex[j]) hit = 0;
                if (hit) return i;
            end
        end
        return -1;
    endfunction

    function void flush_token();
        int k;
        case (mode)
            S_INT, S_INT_DOT: begin
                add_token(K_INT, 0, tok_line, tok_col, tok_len, acc_ovf ? 0 : acc, acc_ovf);
                if (mode == S_INT_DOT)
                    add_token(K_DOT, 0, tok_line, sat_pos(tok_col + tok_len), 1, 0, 0);
            end
            S_FRAC, S_EXP, S_EXPD: add_simple(K_FLOAT, tok_len);
            S_STR, S_ESC: add_simple(K_INVALID, tok_len);
            S_IDENT: begin
                k = keyword_index();
                if (k >= 0) add_token(K_KEYWORD, k, tok_line, tok_col, tok_len, 0, 0);
                else add_simple(K_IDENT, tok_len);
            end
            S_PEND: begin
                case (held_ch)
                    "-": add_simple(K_MINUS, 1);
                    "/": add_simple(K_SLASH, 1);
                    "<": add_simple(K_LT, 1);
                    ">": add_simple(K_GT, 1);
                    default: add_simple(K_INVALID, 1);
                endcase
            end
            default: ;
        endcase
        mode = S_IDLE;
    endfunction

    // true when the byte belongs to the token in progress
    function automatic bit extend_token(byte unsigned c);
        longint unsigned d;
        t_kind k;
        d = c - "0";
        case (mode)
            S_INT: begin
                if (is_digit(c)) begin
                    if (!acc_ovf) begin
                        if (acc > (VAL_MAX - d) / 10) acc_ovf = 1;
                        else acc = acc * 10 + d;
                    end
                    bump_len();
                    return 1;
                end
                if (c == ".") begin
                    mode = S_INT_DOT;
                    return 1;
                end
            end
            S_INT_DOT: if (is_digit(c)) begin
                bump_len();
                bump_len();
                mode = S_FRAC;
                return 1;
            end
            S_FRAC: begin
                if (is_digit(c)) begin
                    bump_len();
                    return 1;
                end
                if (c == "e" || c == "E") begin
                    bump_len();
                    mode = S_EXP;
                    return 1;
                end
            end
            S_EXP: if (c == "+" || c == "-" || is_digit(c)) begin
                bump_len();
                mode = S_EXPD;
                return 1;
            end
            S_EXPD: if (is_digit(c)) begin
                bump_len();
                return 1;
            end
            S_STR: begin
                if (c == quote_ch) begin
                    add_simple(K_STRING, tok_len);
                    mode = S_IDLE;
                end else if (c == "\\") begin
                    mode = S_ESC;
                end else begin
                    bump_len();
                end
                return 1;
            end
            S_ESC: begin
                bump_len();
                mode = S_STR;
                return 1;
            end
            S_IDENT: if (is_alpha(c) || is_digit(c) || c == "_") begin
                if (tok_len < LEX_CHARS) lex[tok_len] = lower(c);
                bump_len();
                return 1;
            end
            S_PEND: begin
                if (held_ch == "-" && c == "-") begin
                    mode = S_LCOM;
                    return 1;
                end
                if (held_ch == "/" && c == "*") begin
                    mode = S_BCOM;
                    return 1;
                end
                if (c == "=" || (held_ch == "<" && c == ">")) begin
                    k = K_INVALID;
                    if (held_ch == "<") k = (c == "=") ? K_LE : K_NE;
                    else if (held_ch == ">") k = K_GE;
                    else if (held_ch == "!") k = K_NE;
                    else if (held_ch == ":") k = K_ASSIGN;
                    if (k != K_INVALID) begin
                        add_simple(k, 2);
                        mode = S_IDLE;
                        return 1;
                    end
                end
            end
            S_LCOM: begin
                if (c == 8'h0A) mode = S_IDLE;
                return 1;
            end
            S_BCOM: begin
                if (c == "*") mode = S_BSTAR;
                return 1;
            end
            S_BSTAR: begin
                if (c == "/") mode = S_IDLE;
                else if (c != "*") mode = S_BCOM;
                return 1;
            end
            default: ;
        endcase
        flush_token();
        return 0;
    endfunction

    function void open_token(t_scan m);
        mode = m;
        tok_line = cur_line;
        tok_col = cur_col;
        tok_len = 0;
    endfunction

    function void start_from_idle(byte unsigned c);
        t_kind k;
        if (c == " " || (c >= 9 && c <= 13)) return;
        if (is_digit(c)) begin
            open_token(S_INT);
            acc = c - "0";
            acc_ovf = 0;
            tok_len = 1;
        end else if (c == "'" || c == "\"") begin
            open_token(S_STR);
            quote_ch = c;
        end else if (is_alpha(c) || c == "_") begin
            open_token(S_IDENT);
            lex[0] = lower(c);
            tok_len = 1;
        end else if (c == "-" || c == "/" || c == "<" || c == ">" || c == "!" || c == ":") begin
            open_token(S_PEND);
            held_ch = c;
        end else begin
            case (c)
                "+": k = K_PLUS;
                "*": k = K_STAR;
                "%": k = K_PERCENT;
                "(": k = K_LPAREN;
                ")": k = K_RPAREN;
                ",": k = K_COMMA;
                ";": k = K_SEMI;
                ".": k = K_DOT;
                "=": k = K_EQ;
                default: k = K_INVALID;
            endcase
            add_token(k, 0, cur_line, cur_col, 1, 0, 0);
        end
    endfunction

    // advance the mirror by one accepted item and queue the tokens it yields
    function void scan_item(byte unsigned c, bit eoi);
        step_toks = {};
        if (eoi || c == 0) begin
            flush_token();
            add_token(K_EOF, 0, cur_line, cur_col, 0, 0, 0);
            clear_scan();
        end else begin
            if (!extend_token(c)) start_from_idle(c);
            if (c == 8'h0A) begin
                cur_line = sat_pos(cur_line + 1);
                cur_col = 1;
            end else begin
                cur_col = sat_pos(cur_col + 1);
            end
        end
        if (step_toks.size() > 0) step_toks[$].last_of_run = 1'b1;
        foreach (step_toks[i]) token_q.push_back(step_toks[i]);
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // stimulus helpers
    function void push_byte(byte unsigned c);
        t_src_item it;
        it.code = c;
        it.eoi = 0;
        byte_q.push_back(it);
        n_added++;
    endfunction

    function void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    function void push_eoi(byte unsigned c);
        t_src_item it;
        it.code = c;
        it.eoi = 1;
        byte_q.push_back(it);
        n_added++;
    endfunction

    function void push_digits(int n);
        for (int i = 0; i < n; i++) push_byte("0" + $urandom_range(0, 9));
    endfunction

    function void push_piece();
        string w;
        byte unsigned c;
        case ($urandom_range(0, 15))
            0, 1, 2: begin
                w = kw_words[$urandom_range(0, 110)];
                for (int i = 0; i < w.len(); i++) begin
                    c = w[i];
                    if ($urandom_range(0, 1) && c >= "a" && c <= "z") c = c & 8'hDF;
                    push_byte(c);
                end
            end
            3: begin
                push_byte($urandom_range(0, 1) ? "_" : "a" + $urandom_range(0, 25));
                repeat ($urandom_range(0, 18)) begin
                    case ($urandom_range(0, 2))
                        0: push_byte("a" + $urandom_range(0, 25));
                        1: push_byte("A" + $urandom_range(0, 25));
                        default: push_byte($urandom_range(0, 1) ? "_" : "0" + $urandom_range(0, 9));
                    endcase
                end
            end
            4: push_digits($urandom_range(1, 21));
            5: begin
                push_digits($urandom_range(1, 4));
                push_byte(".");
                push_digits($urandom_range(1, 3));
                if ($urandom_range(0, 1)) begin
                    push_byte($urandom_range(0, 1) ? "e" : "E");
                    case ($urandom_range(0, 2))
                        0: push_byte("+");
                        1: push_byte("-");
                        default: ;
                    endcase
                    push_digits($urandom_range(1, 3));
                end
            end
            6: begin
                push_digits($urandom_range(1, 3));
                push_byte(".");
            end
            7: begin
                c = $urandom_range(0, 1) ? "'" : "\"";
                push_byte(c);
                repeat ($urandom_range(0, 8)) begin
                    if ($urandom_range(0, 4) == 0) push_byte("\\");
                    push_byte($urandom_range(32, 126));
                end
                push_byte(c);
            end
            8, 9: begin
                case ($urandom_range(0, 18))
                    0: push_text("+");   1: push_text("-");   2: push_text("*");
                    3: push_text("/");   4: push_text("%");   5: push_text("=");
                    6: push_text("<>");  7: push_text("!=");  8: push_text("<");
                    9: push_text("<=");  10: push_text(">");  11: push_text(">=");
                    12: push_text(":="); 13: push_text("(");  14: push_text(")");
                    15: push_text(",");  16: push_text(";");  17: push_text(".");
                    default: push_text($urandom_range(0, 1) ? "!" : ":");
                endcase
            end
            10: push_text($urandom_range(0, 1) ? "-- note\n" : "/* x ** y */");
            11, 12: case ($urandom_range(0, 3))
                0: push_byte(8'h0A);
                1: push_byte(8'h09);
                default: push_byte(" ");
            endcase
            13, 14: push_byte($urandom_range(0, 255));
            default: push_eoi($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 2)) push_byte(" ");
    endfunction

    task automatic wait_drained();
        do @(posedge i_clk);
        while (byte_q.size() != 0 || src_ch.valid || token_q.size() != 0);
    endtask

    task automatic run_random(int n, int src_pct, int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        n_added = 0;
        while (n_added < n) push_piece();
        push_eoi(8'h00);
        wait_drained();
    endtask

    initial begin
        i_clk = 1'b0;
        src_ch.valid = 1'b0;
        src_ch.char_code = 8'h00;
        src_ch.end_of_input = 1'b0;
        tok_ch.ready = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // byte driver
    always @(posedge i_clk) begin
        t_src_item it;
        if (!i_rst_n) begin
            src_ch.valid <= 1'b0;
            src_ch.char_code <= 8'h00;
            src_ch.end_of_input <= 1'b0;
        end else begin
            if (src_ch.valid && src_ch.ready) begin
                scan_item(src_ch.char_code, src_ch.end_of_input);
                n_bytes++;
            end
            if (!src_ch.valid || src_ch.ready) begin
                if (byte_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    it = byte_q.pop_front();
                    src_ch.valid <= 1'b1;
                    src_ch.char_code <= it.code;
                    src_ch.end_of_input <= it.eoi;
                end else begin
                    src_ch.valid <= 1'b0;
                end
            end
        end
    end

    // token monitor
    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            tok_ch.ready <= 1'b0;
        end else begin
            if (tok_ch.valid && tok_ch.ready) begin
                n_tokens++;
                if (token_q.size() == 0) begin
                    $error("token with none expected: kind %0d", tok_ch.token_kind);
                    n_errors++;
                end else begin
                    want = token_q.pop_front();
                    check_field("token_kind", want.token_kind, tok_ch.token_kind);
                    check_field("keyword_code", want.keyword_code, tok_ch.keyword_code);
                    check_field("start_line", want.start_line, tok_ch.start_line);
                    check_field("start_column", want.start_column, tok_ch.start_column);
                    check_field("lexeme_length", want.lexeme_length, tok_ch.lexeme_length);
                    check_field("int_value", want.int_value, tok_ch.int_value);
                    check_field("value_overflow", want.value_overflow, tok_ch.value_overflow);
                    check_field("last_of_run", want.last_of_run, tok_ch.last_of_run);
                end
            end
            tok_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (src_ch.valid && src_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        n_errors = 0;
        n_bytes = 0;
        n_tokens = 0;
        stall_cnt = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        clear_scan();
        foreach (lex[i]) lex[i] = 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: keywords, alias, long ident, overflow, floats, number then dot
        push_text("Select bool AUTO_");
        push_text("INCREMENT abcdefghijklmnopq ");
        push_text("9223372036854775807 9223372036854775808 3.25e+7 1.5E9 42.x ");
        push_text("'it\\'s' \"q\" -- c\n/* a ** */");
        push_text("+-*/%=<>!=<<=>>=:=(),;.!a:");
        push_byte(8'h80);
        push_byte(8'hFF);
        push_eoi(8'hFF);
        push_text("'open");
        push_eoi(8'h00);
        push_text("/* open 7");
        push_byte(8'h00);
        push_text("x");
        push_eoi(8'h55);
        run_random(12, 19, 70);
        run_random(12, 70, 19);
        run_random(12, 0, 0);
        repeat (20) @(posedge i_clk);

        $display("scanned %0d source bytes into %0d tokens over three handshake mixes",
                 n_bytes, n_tokens);
        $display("plus directed keyword, number, string, comment and operator cases");
        if (n_errors == 0 && token_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/sqlts_pkg.sv
design/sqlts_if.sv
design/sqlts_kw_match.sv
design/sqlts_core.sv
design/sqlts_out_fifo.sv
design/sql_token_scanner_top.sv
verif/sql_token_scanner_top_test.sv
